FILE: src/cft_pkg.sv
// types and constants shared by the delimited-text field tokenizer
// no dependencies
package cft_pkg;

	localparam int unsigned ROW_W  = 16;
	localparam int unsigned CELL_W = 20;
	localparam int unsigned COL_W  = 10;
	localparam int unsigned LEN_W  = 12;
	localparam int unsigned CNT_W  = COL_W + 1;

	localparam logic [2:0] REG_DELIMITER  = 3'd0;
	localparam logic [2:0] REG_QUOTE      = 3'd1;
	localparam logic [2:0] REG_NEWLINE    = 3'd2;
	localparam logic [2:0] REG_FIRST_ROW  = 3'd3;
	localparam logic [2:0] REG_FIRST_CELL = 3'd4;

	localparam logic [7:0] RST_DELIMITER = 8'd44;
	localparam logic [7:0] RST_QUOTE     = 8'd34;
	localparam logic [7:0] RST_NEWLINE   = 8'd10;

	localparam logic CMD_END = 1'b1;

	typedef enum logic [1:0] {
		KIND_DATA      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_ROW_END   = 2'd2,
		KIND_BUF_DONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]        delimiter_char;
		logic [7:0]        quote_char;
		logic [7:0]        newline_char;
		logic [ROW_W-1:0]  first_row;
		logic [CELL_W-1:0] first_cell;
	} cfg_t;

	typedef struct packed {
		logic              in_quote;
		logic [LEN_W-1:0]  field_bytes;
		logic [COL_W-1:0]  fields_in_row;
		logic [ROW_W-1:0]  rows_closed;
		logic [CELL_W-1:0] cells_closed;
	} tok_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data_byte;
		logic [CELL_W-1:0] cell_index;
		logic [ROW_W-1:0]  row_index;
		logic [CNT_W-1:0]  column_count;
		logic [LEN_W-1:0]  field_length;
		logic [ROW_W-1:0]  rows_done;
	} result_t;

endpackage

FILE: src/csv_field_tokenizer_unit.sv
// delimited-text field tokenizer with quoted sections, top level
// a result word is registered and appears in the cycle after its input word is accepted
// throughput: one input word per cycle; the single output register holds back input only
// while its word waits and the sink is stalled
// reset: arst_n clears tokenizer state and output valid, registers return to defaults
// depends on cft_pkg and cft_step
module csv_field_tokenizer_unit #(
	parameter int unsigned ROW_CAPACITY  = 65536,
	parameter int unsigned MAX_CELLS     = 1048576,
	parameter int unsigned MAX_COLUMNS   = 1024,
	parameter int unsigned MAX_FIELD_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // text_byte
	input  logic [0:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// data_byte, cell_index, row_index, column_count, field_length, rows_done, zero pad
	output logic [87:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser    // kind
);
	import cft_pkg::*;

	localparam int unsigned ROWS_M1  = ROW_CAPACITY - 1;
	localparam int unsigned CELLS_M1 = MAX_CELLS - 1;
	localparam int unsigned COLS_M1  = MAX_COLUMNS - 1;
	localparam int unsigned LEN_M1   = MAX_FIELD_LEN - 1;
	localparam logic [ROW_W-1:0]  LIM_ROWS  = (ROWS_M1 < 65535) ? ROW_W'(ROWS_M1) : '1;
	localparam logic [CELL_W-1:0] LIM_CELLS = (CELLS_M1 < 1048575) ? CELL_W'(CELLS_M1) : '1;
	localparam logic [COL_W-1:0]  LIM_COLS  = (COLS_M1 < 1023) ? COL_W'(COLS_M1) : '1;
	localparam logic [LEN_W-1:0]  LIM_LEN   = (LEN_M1 < 4095) ? LEN_W'(LEN_M1) : '1;

	cfg_t       cfg_q;
	tok_state_t state_q;
	tok_state_t state_nxt;
	result_t    res;
	result_t    res_q;
	logic       emit;
	logic       m_valid_q;
	logic       s_acc;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_char <= RST_DELIMITER;
			cfg_q.quote_char     <= RST_QUOTE;
			cfg_q.newline_char   <= RST_NEWLINE;
			cfg_q.first_row      <= '0;
			cfg_q.first_cell     <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_DELIMITER:  cfg_q.delimiter_char <= pwdata[7:0];
				REG_QUOTE:      cfg_q.quote_char     <= pwdata[7:0];
				REG_NEWLINE:    cfg_q.newline_char   <= pwdata[7:0];
				REG_FIRST_ROW:  cfg_q.first_row      <= pwdata[ROW_W-1:0];
				REG_FIRST_CELL: cfg_q.first_cell     <= pwdata[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_DELIMITER:  prdata = {24'd0, cfg_q.delimiter_char};
			REG_QUOTE:      prdata = {24'd0, cfg_q.quote_char};
			REG_NEWLINE:    prdata = {24'd0, cfg_q.newline_char};
			REG_FIRST_ROW:  prdata = {16'd0, cfg_q.first_row};
			REG_FIRST_CELL: prdata = {12'd0, cfg_q.first_cell};
			default:        prdata = '0;
		endcase
	end

	cft_step #(
		.LIM_ROWS  (LIM_ROWS),
		.LIM_CELLS (LIM_CELLS),
		.LIM_COLS  (LIM_COLS),
		.LIM_LEN   (LIM_LEN)
	) u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.command   (s_axis_tuser[0]),
		.text_byte (s_axis_tdata),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				state_q <= state_nxt;
			end
			if (s_acc && emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc && emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {5'd0, res_q.rows_done, res_q.field_length, res_q.column_count,
		res_q.row_index, res_q.cell_index, res_q.data_byte};

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tuser[0] == CMD_END |=> state_q == '0)
		else $error("state not cleared after end of buffer");

	a_quote_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tuser[0] != CMD_END && s_axis_tdata == cfg_q.quote_char
		|=> state_q.in_quote != $past(state_q.in_quote))
		else $error("quote word did not toggle quote flag");

	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.field_bytes <= LIM_LEN && state_q.fields_in_row <= LIM_COLS)
		else $error("counter beyond its limit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_no_result_on_quote: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q && s_acc && s_axis_tuser[0] != CMD_END
		&& s_axis_tdata == cfg_q.quote_char |=> !m_valid_q)
		else $error("result produced for a quote word");

endmodule

FILE: src/cft_step.sv
// per-word classification and counter update of the tokenizer
// depends on cft_pkg
module cft_step #(
	parameter logic [15:0] LIM_ROWS  = 16'hFFFF,
	parameter logic [19:0] LIM_CELLS = 20'hFFFFF,
	parameter logic [9:0]  LIM_COLS  = 10'h3FF,
	parameter logic [11:0] LIM_LEN   = 12'hFFF
) (
	input  cft_pkg::cfg_t       cfg,
	input  cft_pkg::tok_state_t cur,
	input  logic                command,
	input  logic [7:0]          text_byte,
	output cft_pkg::tok_state_t nxt,
	output logic                emit,
	output cft_pkg::result_t    res
);
	import cft_pkg::*;

	logic [CELL_W:0]   cell_sum;
	logic [ROW_W:0]    row_sum;
	logic [CELL_W-1:0] cell_idx;
	logic [ROW_W-1:0]  row;
	logic [CNT_W-1:0]  cols;
	logic [ROW_W-1:0]  rows_inc;
	logic [CELL_W-1:0] cells_inc;
	logic [COL_W-1:0]  fields_inc;
	logic [LEN_W-1:0]  len_inc;
	logic              pending;

	always_comb begin
		cell_sum   = {1'b0, cfg.first_cell} + {1'b0, cur.cells_closed};
		row_sum    = {1'b0, cfg.first_row} + {1'b0, cur.rows_closed};
		cell_idx   = cell_sum[CELL_W] ? '1 : cell_sum[CELL_W-1:0];
		row        = row_sum[ROW_W] ? '1 : row_sum[ROW_W-1:0];
		cols       = {1'b0, cur.fields_in_row} + CNT_W'(1);
		rows_inc   = (cur.rows_closed < LIM_ROWS) ? cur.rows_closed + ROW_W'(1) : LIM_ROWS;
		cells_inc  = (cur.cells_closed < LIM_CELLS) ? cur.cells_closed + CELL_W'(1)
			: LIM_CELLS;
		fields_inc = (cur.fields_in_row < LIM_COLS) ? cur.fields_in_row + COL_W'(1)
			: LIM_COLS;
		len_inc    = (cur.field_bytes < LIM_LEN) ? cur.field_bytes + LEN_W'(1) : LIM_LEN;
		pending    = (cur.field_bytes != '0) || (cur.fields_in_row != '0);

		nxt  = cur;
		emit = 1'b1;
		res  = '{kind: KIND_DATA, data_byte: 8'd0, cell_index: cell_idx, row_index: row,
			column_count: '0, field_length: '0, rows_done: cur.rows_closed};

		priority if (command == CMD_END) begin
			res.kind = KIND_BUF_DONE;
			if (pending) begin
				res.column_count = cols;
				res.field_length = cur.field_bytes;
				res.rows_done    = rows_inc;
			end
			nxt = '0;
		end else if (text_byte == cfg.quote_char) begin
			nxt.in_quote = ~cur.in_quote;
			emit         = 1'b0;
		end else if (!cur.in_quote && text_byte == cfg.newline_char) begin
			res.kind          = KIND_ROW_END;
			res.column_count  = cols;
			res.field_length  = cur.field_bytes;
			res.rows_done     = rows_inc;
			nxt.rows_closed   = rows_inc;
			nxt.cells_closed  = cells_inc;
			nxt.field_bytes   = '0;
			nxt.fields_in_row = '0;
		end else if (!cur.in_quote && text_byte == cfg.delimiter_char) begin
			res.kind          = KIND_FIELD_END;
			res.field_length  = cur.field_bytes;
			nxt.cells_closed  = cells_inc;
			nxt.fields_in_row = fields_inc;
			nxt.field_bytes   = '0;
		end else begin
			res.data_byte    = text_byte;
			res.field_length = len_inc;
			nxt.field_bytes  = len_inc;
		end
	end

endmodule
